>>> hdl/lss_pkg.sv
// Package of shared types and constants for the loop and subroutine stack.
package lss_pkg;

  localparam int unsigned VAR_COUNT = 32;

  typedef enum logic [1:0] {
    CMD_FOR    = 2'd0,
    CMD_NEXT   = 2'd1,
    CMD_GOSUB  = 2'd2,
    CMD_RETURN = 2'd3
  } cmd_t;

  localparam logic [2:0] STAT_OK         = 3'd0;
  localparam logic [2:0] STAT_FOR_OVF    = 3'd1;
  localparam logic [2:0] STAT_NEXT_NOFOR = 3'd2;
  localparam logic [2:0] STAT_GOSUB_OVF  = 3'd3;
  localparam logic [2:0] STAT_RET_NOSUB  = 3'd4;

  typedef struct packed {
    cmd_t               command;
    logic [4:0]         var_index;
    logic               next_named;
    logic signed [15:0] current_value;
    logic signed [15:0] limit_value;
    logic signed [15:0] step_value;
    logic [15:0]        return_line;
    logic [15:0]        return_pos;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               write_var;
    logic signed [15:0] var_value;
    logic               loop_done;
    logic               jump;
    logic               resume_in_place;
    logic [15:0]        jump_line;
    logic [15:0]        jump_pos;
    logic               stop_run;
  } out_t;

  typedef struct packed {
    logic [4:0]         var_idx;
    logic signed [15:0] limit;
    logic signed [15:0] step;
    logic [15:0]        ret_line;
    logic [15:0]        ret_pos;
  } frame_t;

  typedef struct packed {
    logic [15:0] ret_line;
    logic [15:0] ret_pos;
  } call_frame_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic emit;
  } ctl_t;

  typedef struct packed {
    logic scan_hit;
    logic scan_end;
  } sts_t;

endpackage

>>> hdl/lss_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

>>> hdl/lss_ctrl.sv
// Controller state machine sequencing accept, frame search and result commit.
module lss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  lss_pkg::cmd_t     in_cmd,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  lss_pkg::sts_t     sts,
  output lss_pkg::ctl_t     ctl
);

  lss_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lss_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_cmd == lss_pkg::CMD_FOR || in_cmd == lss_pkg::CMD_NEXT) begin
            state_nxt = lss_pkg::ST_SCAN;
          end else begin
            state_nxt = lss_pkg::ST_EMIT;
          end
        end
      end
      lss_pkg::ST_SCAN: begin
        if (sts.scan_hit || sts.scan_end) begin
          state_nxt = lss_pkg::ST_EMIT;
        end
      end
      lss_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = lss_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lss_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.load = (state_r == lss_pkg::ST_IDLE) && in_valid;
    ctl.scan = (state_r == lss_pkg::ST_SCAN);
    ctl.emit = (state_r == lss_pkg::ST_EMIT) && (!out_valid_r || out_ready);
    in_ready = (state_r == lss_pkg::ST_IDLE);
    out_valid = out_valid_r;
    if (ctl.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lss_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hdl/lss_datapath.sv
// Datapath holding the stack pointers, frame memories, search and result logic.
module lss_datapath #(
  parameter int LOOP_DEPTH = 16,
  parameter int CALL_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  lss_pkg::in_t   in_data,
  input  lss_pkg::ctl_t  ctl,
  output lss_pkg::sts_t  sts,
  output lss_pkg::out_t  out_data
);

  localparam int LI = $clog2(LOOP_DEPTH);
  localparam int LT = $clog2(LOOP_DEPTH + 1);
  localparam int CI = $clog2(CALL_DEPTH);
  localparam int CT = $clog2(CALL_DEPTH + 1);
  localparam int FW = $bits(lss_pkg::frame_t);
  localparam int CW = $bits(lss_pkg::call_frame_t);

  lss_pkg::in_t        item_r;
  lss_pkg::frame_t     frame_r;
  lss_pkg::out_t       out_r;
  lss_pkg::out_t       res;
  logic [LT-1:0]       loop_top_r, loop_top_nxt;
  logic [CT-1:0]       call_top_r, call_top_nxt;
  logic [LT-1:0]       cnt_r, cnt_dec;
  logic [LI-1:0]       rd_idx_r, k_r, lraddr, lwaddr;
  logic                pend_r, found_r;
  logic                use_name, match;
  lss_pkg::in_t        in_red;
  logic [FW-1:0]       lrdata;
  lss_pkg::frame_t     lrd, lwdata;
  logic                lwe, cwe;
  logic [CI-1:0]       craddr, cwaddr;
  logic [CT-1:0]       ctop_dec;
  logic [CW-1:0]       crdata;
  lss_pkg::call_frame_t crd, cwdata;
  logic [LT-1:0]       base, f_cnt;
  logic signed [16:0]  sum, lim17;
  logic                ovf, fin;

  lss_ram #(.WIDTH(FW), .DEPTH(LOOP_DEPTH)) u_loop_ram (
    .clk     (clk),
    .we      (lwe),
    .waddr   (lwaddr),
    .wdata   (lwdata),
    .raddr   (lraddr),
    .rdata_r (lrdata)
  );

  lss_ram #(.WIDTH(CW), .DEPTH(CALL_DEPTH)) u_call_ram (
    .clk     (clk),
    .we      (cwe),
    .waddr   (cwaddr),
    .wdata   (cwdata),
    .raddr   (craddr),
    .rdata_r (crdata)
  );

  assign lrd = lss_pkg::frame_t'(lrdata);
  assign crd = lss_pkg::call_frame_t'(crdata);

  always_comb begin
    in_red = in_data;
    if ({4'b0, in_data.var_index} >= 9'(lss_pkg::VAR_COUNT)) begin
      in_red.var_index = 5'({4'b0, in_data.var_index} - 9'(lss_pkg::VAR_COUNT));
    end
  end

  always_comb begin
    use_name = (item_r.command == lss_pkg::CMD_FOR) || item_r.next_named;
    match    = pend_r && (!use_name || (lrd.var_idx == item_r.var_index));
    sts.scan_hit = match;
    sts.scan_end = !match && !pend_r && (cnt_r == '0);
    cnt_dec  = cnt_r - LT'(1);
    lraddr   = cnt_dec[LI-1:0];
    ctop_dec = call_top_r - CT'(1);
    craddr   = ctop_dec[CI-1:0];
    cwaddr   = call_top_r[CI-1:0];
  end

  always_comb begin
    res          = '0;
    loop_top_nxt = loop_top_r;
    call_top_nxt = call_top_r;
    lwe          = 1'b0;
    cwe          = 1'b0;
    base         = found_r ? LT'(k_r) : loop_top_r;
    f_cnt        = LT'(k_r) + LT'(1);
    lwaddr       = base[LI-1:0];
    lwdata.var_idx  = item_r.var_index;
    lwdata.limit    = item_r.limit_value;
    lwdata.step     = item_r.step_value;
    lwdata.ret_line = item_r.return_line;
    lwdata.ret_pos  = item_r.return_pos;
    cwdata.ret_line = item_r.return_line;
    cwdata.ret_pos  = item_r.return_pos;
    sum   = 17'(item_r.current_value) + 17'(frame_r.step);
    lim17 = 17'(frame_r.limit);
    ovf   = sum[16] != sum[15];
    fin   = ovf || (frame_r.step > 16'sd0 && sum > lim17) ||
            (frame_r.step < 16'sd0 && sum < lim17);
    unique case (item_r.command)
      lss_pkg::CMD_FOR: begin
        res.write_var = 1'b1;
        res.var_value = item_r.current_value;
        loop_top_nxt  = base;
        if (base >= LT'(LOOP_DEPTH)) begin
          res.status = lss_pkg::STAT_FOR_OVF;
        end else begin
          lwe          = ctl.emit;
          loop_top_nxt = base + LT'(1);
        end
      end
      lss_pkg::CMD_NEXT: begin
        if (!found_r) begin
          res.status = lss_pkg::STAT_NEXT_NOFOR;
        end else begin
          res.write_var = 1'b1;
          res.var_value = ovf ? item_r.current_value : sum[15:0];
          loop_top_nxt  = f_cnt;
          if (fin) begin
            loop_top_nxt  = LT'(k_r);
            res.loop_done = 1'b1;
          end else if (frame_r.ret_line == 16'd0) begin
            res.resume_in_place = 1'b1;
            res.jump_pos        = frame_r.ret_pos;
          end else begin
            res.jump      = 1'b1;
            res.jump_line = frame_r.ret_line;
            res.jump_pos  = frame_r.ret_pos;
          end
        end
      end
      lss_pkg::CMD_GOSUB: begin
        if (call_top_r >= CT'(CALL_DEPTH)) begin
          res.status = lss_pkg::STAT_GOSUB_OVF;
        end else begin
          cwe          = ctl.emit;
          call_top_nxt = call_top_r + CT'(1);
        end
      end
      lss_pkg::CMD_RETURN: begin
        if (call_top_r == '0) begin
          res.status = lss_pkg::STAT_RET_NOSUB;
        end else begin
          call_top_nxt = ctop_dec;
          if (crd.ret_line == 16'd0) begin
            res.stop_run = 1'b1;
          end else begin
            res.jump      = 1'b1;
            res.jump_line = crd.ret_line;
            res.jump_pos  = crd.ret_pos;
          end
        end
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_top_r <= '0;
      call_top_r <= '0;
      pend_r     <= 1'b0;
      found_r    <= 1'b0;
      cnt_r      <= '0;
    end else if (ctl.load) begin
      cnt_r   <= loop_top_r;
      pend_r  <= 1'b0;
      found_r <= 1'b0;
    end else if (ctl.scan) begin
      if (match) begin
        found_r <= 1'b1;
      end
      pend_r <= (cnt_r != '0);
      if (cnt_r != '0) begin
        cnt_r <= cnt_dec;
      end
    end else if (ctl.emit) begin
      loop_top_r <= loop_top_nxt;
      call_top_r <= call_top_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_r <= in_red;
    end
    if (ctl.scan) begin
      if (cnt_r != '0) begin
        rd_idx_r <= lraddr;
      end
      if (match) begin
        k_r     <= rd_idx_r;
        frame_r <= lrd;
      end
    end
    if (ctl.emit) begin
      out_r <= res;
    end
  end

  assign out_data = out_r;

endmodule

>>> hdl/loop_and_subroutine_stack.sv
// Top level of the loop-frame stack and return stack of a BASIC control unit.
//
// An item enters on in_data with in_valid/in_ready and carries one FOR, NEXT,
// GOSUB or RETURN statement. Each item produces exactly one result item on
// out_data with out_valid/out_ready, in order.
// GOSUB and RETURN go from the accept straight to loading their result.
// FOR and NEXT search the loop frames from the top down through the loop
// frame memory, one frame per cycle, and load their result once a frame
// matches or the search has passed the bottom of the stack. One item is in
// work at a time; the input is ready again in the cycle after the result is
// loaded. A new item is accepted even if the receiver has not taken the
// previous result yet.
// While the receiver stalls, the block holds its result and finishes at most
// one further item, which then waits for the output slot.
// A synchronous reset empties both stacks at once; the frame memories
// themselves are not cleared and need no clearing pass.
module loop_and_subroutine_stack #(
  parameter int LOOP_DEPTH = 16,
  parameter int CALL_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lss_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output lss_pkg::out_t out_data
);

  lss_pkg::ctl_t ctl;
  lss_pkg::sts_t sts;

  lss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_data.command),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  lss_datapath #(
    .LOOP_DEPTH (LOOP_DEPTH),
    .CALL_DEPTH (CALL_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .ctl      (ctl),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the loop and subroutine stack with directed and random statements.
module testbench;

  localparam int LOOP_DEPTH   = 16;
  localparam int CALL_DEPTH   = 16;
  localparam int RANDOM_STMTS = 1650;
  localparam int TAIL_CYCLES  = 2 * (LOOP_DEPTH + 3);
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_PERIOD = 400;

  typedef struct packed {
    int                                    loop_top;
    int                                    call_top;
    lss_pkg::frame_t [LOOP_DEPTH-1:0]      loops;
    lss_pkg::call_frame_t [CALL_DEPTH-1:0] calls;
  } stacks_t;

  typedef struct packed {
    logic         drain;
    lss_pkg::in_t stmt;
  } queued_stmt_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  lss_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  lss_pkg::out_t out_data;

  stacks_t       dut_stacks;
  stacks_t       plan_stacks;
  queued_stmt_t  stmt_queue[$];
  queued_stmt_t  next_stmt;
  lss_pkg::out_t expected_outcomes[$];
  int            stmts_queued = 0;
  int            outcomes_seen = 0;
  int            errors = 0;
  int            cycles = 0;
  int            send_gap = 0;
  int            recv_wait = 0;
  bit            send_calm = 1'b0;
  bit            recv_calm = 1'b0;
  bit            in_fired = 1'b0;
  bit            out_fired = 1'b0;

  loop_and_subroutine_stack #(
    .LOOP_DEPTH(LOOP_DEPTH),
    .CALL_DEPTH(CALL_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  function automatic int top_frame_of(input stacks_t st, input logic [4:0] v);
    for (int i = st.loop_top; i > 0; i--) begin
      if (st.loops[i-1].var_idx == v) return i;
    end
    return 0;
  endfunction

  function automatic lss_pkg::out_t step_stacks(inout stacks_t st, input lss_pkg::in_t it);
    lss_pkg::out_t        r;
    logic [4:0]           vidx;
    int                   hit, cur, stp, lim, sum;
    bit                   fin;
    lss_pkg::frame_t      fr;
    lss_pkg::call_frame_t cf;
    r = '0;
    vidx = 5'(int'(it.var_index) % lss_pkg::VAR_COUNT);
    case (it.command)
      lss_pkg::CMD_FOR: begin
        r.write_var = 1'b1;
        r.var_value = it.current_value;
        hit = top_frame_of(st, vidx);
        if (hit > 0) st.loop_top = hit - 1;
        if (st.loop_top >= LOOP_DEPTH) begin
          r.status = lss_pkg::STAT_FOR_OVF;
        end else begin
          fr.var_idx = vidx;
          fr.limit = it.limit_value;
          fr.step = it.step_value;
          fr.ret_line = it.return_line;
          fr.ret_pos = it.return_pos;
          st.loops[st.loop_top] = fr;
          st.loop_top++;
        end
      end
      lss_pkg::CMD_NEXT: begin
        hit = it.next_named ? top_frame_of(st, vidx) : st.loop_top;
        if (hit == 0) begin
          r.status = lss_pkg::STAT_NEXT_NOFOR;
        end else begin
          fr = st.loops[hit-1];
          st.loop_top = hit;
          cur = int'(it.current_value);
          stp = int'(fr.step);
          lim = int'(fr.limit);
          sum = cur + stp;
          if (sum > 32767 || sum < -32768) begin
            fin = 1'b1;
          end else begin
            cur = sum;
            fin = (stp > 0 && cur > lim) || (stp < 0 && cur < lim);
          end
          r.write_var = 1'b1;
          r.var_value = 16'(cur);
          if (fin) begin
            st.loop_top = hit - 1;
            r.loop_done = 1'b1;
          end else if (fr.ret_line == '0) begin
            r.resume_in_place = 1'b1;
            r.jump_pos = fr.ret_pos;
          end else begin
            r.jump = 1'b1;
            r.jump_line = fr.ret_line;
            r.jump_pos = fr.ret_pos;
          end
        end
      end
      lss_pkg::CMD_GOSUB: begin
        if (st.call_top >= CALL_DEPTH) begin
          r.status = lss_pkg::STAT_GOSUB_OVF;
        end else begin
          cf.ret_line = it.return_line;
          cf.ret_pos = it.return_pos;
          st.calls[st.call_top] = cf;
          st.call_top++;
        end
      end
      default: begin
        if (st.call_top == 0) begin
          r.status = lss_pkg::STAT_RET_NOSUB;
        end else begin
          st.call_top--;
          cf = st.calls[st.call_top];
          if (cf.ret_line == '0) begin
            r.stop_run = 1'b1;
          end else begin
            r.jump = 1'b1;
            r.jump_line = cf.ret_line;
            r.jump_pos = cf.ret_pos;
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 10) begin
        $display("result %0d: %s expected %h, got %h", outcomes_seen, name, want, got);
      end
    end
  endtask

  task automatic check_outcome(input lss_pkg::out_t got);
    lss_pkg::out_t want;
    outcomes_seen++;
    if (expected_outcomes.size() == 0) begin
      errors++;
      if (errors <= 10) $display("result %0d arrived with none expected: %h", outcomes_seen, got);
    end else begin
      want = expected_outcomes.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("write_var", want.write_var, got.write_var);
      compare_field("var_value", want.var_value, got.var_value);
      compare_field("loop_done", want.loop_done, got.loop_done);
      compare_field("jump", want.jump, got.jump);
      compare_field("resume_in_place", want.resume_in_place, got.resume_in_place);
      compare_field("jump_line", want.jump_line, got.jump_line);
      compare_field("jump_pos", want.jump_pos, got.jump_pos);
      compare_field("stop_run", want.stop_run, got.stop_run);
    end
  endtask

  function automatic lss_pkg::in_t rand_item();
    logic [95:0] raw;
    raw = {$urandom(), $urandom(), $urandom()};
    return raw[$bits(lss_pkg::in_t)-1:0];
  endfunction

  function automatic lss_pkg::in_t make_item(input lss_pkg::cmd_t c, input logic [4:0] v,
                                             input logic named, input int cur, input int lim,
                                             input int stp, input int line, input int pos);
    lss_pkg::in_t it;
    it = '0;
    it.command = c;
    it.var_index = v;
    it.next_named = named;
    it.current_value = 16'(cur);
    it.limit_value = 16'(lim);
    it.step_value = 16'(stp);
    it.return_line = 16'(line);
    it.return_pos = 16'(pos);
    return it;
  endfunction

  function automatic logic [4:0] pick_var();
    if ($urandom_range(0, 9) < 7) return 5'($urandom_range(0, 7));
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [4:0] live_var();
    if (plan_stacks.loop_top > 0) begin
      return plan_stacks.loops[$urandom_range(0, plan_stacks.loop_top - 1)].var_idx;
    end
    return pick_var();
  endfunction

  function automatic int rand_step();
    int sel, mag;
    sel = $urandom_range(0, 9);
    mag = $urandom_range(1, 3);
    if (sel < 7) return ($urandom_range(0, 1) == 0) ? mag : -mag;
    if (sel == 7) return 0;
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  task automatic queue_item(input lss_pkg::in_t it);
    queued_stmt_t q;
    void'(step_stacks(plan_stacks, it));
    q.drain = (stmts_queued % DRAIN_PERIOD == DRAIN_PERIOD / 2);
    q.stmt = it;
    stmt_queue.push_back(q);
    stmts_queued++;
  endtask

  task automatic add_for(input logic [4:0] v, input bit direct);
    lss_pkg::in_t it;
    int           start, stp;
    it = rand_item();
    start = int'($urandom_range(0, 400)) - 200;
    stp = rand_step();
    it.command = lss_pkg::CMD_FOR;
    it.var_index = v;
    it.current_value = 16'(start);
    it.step_value = 16'(stp);
    if (stp != 0) it.limit_value = 16'(start + stp * int'($urandom_range(0, 6)));
    if (direct) it.return_line = '0;
    queue_item(it);
  endtask

  task automatic add_next(input logic named, input logic [4:0] v, input bit finish);
    lss_pkg::in_t    it;
    int              hit, c;
    lss_pkg::frame_t fr;
    it = rand_item();
    it.command = lss_pkg::CMD_NEXT;
    it.next_named = named;
    it.var_index = v;
    hit = named ? top_frame_of(plan_stacks, v) : plan_stacks.loop_top;
    if (hit > 0) begin
      fr = plan_stacks.loops[hit-1];
      if (!finish) begin
        c = int'(fr.limit) - int'(fr.step) * int'($urandom_range(1, 4));
      end else if ($urandom_range(0, 7) == 0) begin
        c = (fr.step < 0) ? -32768 : 32767;
      end else begin
        c = int'(fr.limit);
      end
      if (c > 32767 || c < -32768) c = int'(fr.limit);
      it.current_value = 16'(c);
    end
    queue_item(it);
  endtask

  task automatic add_call();
    lss_pkg::in_t it;
    it = rand_item();
    it.command = lss_pkg::CMD_GOSUB;
    if ($urandom_range(0, 5) == 0) it.return_line = '0;
    queue_item(it);
  endtask

  task automatic add_return();
    lss_pkg::in_t it;
    it = rand_item();
    it.command = lss_pkg::CMD_RETURN;
    queue_item(it);
  endtask

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    in_fired = 1'b0;
    out_fired = 1'b0;
    if (rst_n) begin
      if (out_valid === 1'b1 && out_ready) begin
        out_fired = 1'b1;
        check_outcome(out_data);
      end
      if (in_valid && in_ready === 1'b1) begin
        in_fired = 1'b1;
        expected_outcomes.push_back(step_stacks(dut_stacks, in_data));
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_fired) begin
        if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
        send_gap = send_calm ? 0 : $urandom_range(0, 11);
      end
      if (!in_valid || in_fired) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (stmt_queue.size() > 0 &&
                     !(stmt_queue[0].drain && expected_outcomes.size() > 0)) begin
          next_stmt = stmt_queue.pop_front();
          in_data <= next_stmt.stmt;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_fired) begin
        if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
        recv_wait = recv_calm ? 0 : $urandom_range(0, 11);
      end
      out_ready <= (recv_wait == 0);
      if (recv_wait > 0 && out_valid === 1'b1) recv_wait--;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("loop_and_subroutine_stack test failed");
      $finish;
    end
  end

  initial begin
    int pick, n, base, goal;
    dut_stacks = '0;
    plan_stacks = '0;

    queue_item(make_item(lss_pkg::CMD_RETURN, 5'd0, 1'b0, 0, 0, 0, 0, 0));
    queue_item(make_item(lss_pkg::CMD_NEXT, 5'd0, 1'b0, 0, 0, 0, 0, 0));
    queue_item(make_item(lss_pkg::CMD_NEXT, 5'd31, 1'b1, -1, 0, 0, 0, 0));
    queue_item(make_item(lss_pkg::CMD_FOR, 5'd31, 1'b0, -32768, 32767, 1, 'hffff, 'hffff));
    queue_item(make_item(lss_pkg::CMD_NEXT, 5'd31, 1'b1, 100, 0, 0, 0, 0));
    queue_item(make_item(lss_pkg::CMD_FOR, 5'd0, 1'b0, 32767, -32768, 0, 0, 5));
    queue_item(make_item(lss_pkg::CMD_NEXT, 5'd0, 1'b0, 32767, 0, 0, 0, 0));
    queue_item(make_item(lss_pkg::CMD_FOR, 5'd31, 1'b0, 5, -5, -1, 1, 2));
    queue_item(make_item(lss_pkg::CMD_NEXT, 5'd31, 1'b1, -5, 0, 0, 0, 0));
    queue_item(make_item(lss_pkg::CMD_FOR, 5'd7, 1'b0, 0, 32767, 32767, 100, 3));
    queue_item(make_item(lss_pkg::CMD_NEXT, 5'd7, 1'b1, 32767, 0, 0, 0, 0));
    queue_item(make_item(lss_pkg::CMD_FOR, 5'd9, 1'b0, 0, -32768, -32768, 200, 4));
    queue_item(make_item(lss_pkg::CMD_NEXT, 5'd9, 1'b0, -1, 0, 0, 0, 0));
    queue_item(make_item(lss_pkg::CMD_FOR, 5'd3, 1'b0, 0, 10, 1, 300, 8));
    queue_item(make_item(lss_pkg::CMD_FOR, 5'd4, 1'b0, 0, 10, 1, 400, 9));
    queue_item(make_item(lss_pkg::CMD_NEXT, 5'd3, 1'b1, 0, 0, 0, 0, 0));
    queue_item(make_item(lss_pkg::CMD_NEXT, 5'd0, 1'b0, 10, 0, 0, 0, 0));
    queue_item(make_item(lss_pkg::CMD_GOSUB, 5'd0, 1'b0, 0, 0, 0, 0, 7));
    queue_item(make_item(lss_pkg::CMD_GOSUB, 5'd0, 1'b0, 0, 0, 0, 'hffff, 'hffff));
    queue_item(make_item(lss_pkg::CMD_RETURN, 5'd0, 1'b0, 0, 0, 0, 0, 0));
    queue_item(make_item(lss_pkg::CMD_RETURN, 5'd0, 1'b0, 0, 0, 0, 0, 0));

    goal = stmts_queued + RANDOM_STMTS;
    while (stmts_queued < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        repeat ($urandom_range(1, 4)) add_for(pick_var(), $urandom_range(0, 7) == 0);
        repeat ($urandom_range(2, 10)) begin
          n = $urandom_range(0, 9);
          if (n < 5) begin
            add_next($urandom_range(0, 4) != 0, live_var(), 1'b0);
          end else if (n < 7) begin
            add_next($urandom_range(0, 4) != 0, live_var(), 1'b1);
          end else if (n < 8) begin
            add_call();
            add_next(1'b1, live_var(), 1'b0);
            add_return();
          end else begin
            add_for(pick_var(), 1'b0);
          end
        end
      end else if (pick < 60) begin
        n = $urandom_range(1, 18);
        repeat (n) add_call();
        repeat ($urandom_range(0, n + 2)) add_return();
      end else if (pick < 70) begin
        base = $urandom_range(0, 31);
        n = $urandom_range(10, 20);
        for (int i = 0; i < n; i++) add_for(5'((base + i) % 32), $urandom_range(0, 7) == 0);
      end else if (pick < 80) begin
        n = plan_stacks.loop_top + 1;
        repeat (n) add_next(1'b0, pick_var(), 1'b1);
        n = plan_stacks.call_top + 1;
        repeat (n) add_return();
      end else begin
        repeat ($urandom_range(1, 4)) queue_item(rand_item());
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (stmt_queue.size() > 0 || in_valid || expected_outcomes.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && expected_outcomes.size() == 0) begin
      $display("loop_and_subroutine_stack test passed");
    end else begin
      $display("loop_and_subroutine_stack test failed");
    end
    $finish;
  end

endmodule
